// File: src/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define D4W_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("d4w assertion failed");

// condition in one cycle implies condition in the next
`define D4W_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    `D4W_ASSERT(lbl, clk, rstn, (a) |=> (b))

`endif

// File: src/d4w_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers of the d4 wavelet core
// no dependencies
package d4w_pkg;

    localparam int DEF_IMG_WIDTH      = 128;
    localparam int DEF_IMG_HEIGHT     = 128;
    localparam int DEF_COEF_FRAC_BITS = 14;

    localparam int CHAN    = 3;
    localparam int COEF_W  = 24;
    localparam int PIX_W   = 8;
    localparam int SCALE_W = 16;
    localparam int PROD_W  = PIX_W + SCALE_W;
    localparam int TAP_W   = 18;
    localparam int ACC_W   = 44;
    localparam int WORD_W  = CHAN * COEF_W;

    localparam logic [SCALE_W-1:0] NORM_RESET = 16'd512;

    localparam logic signed [TAP_W-1:0] TAP_C0 = 18'sd31651;
    localparam logic signed [TAP_W-1:0] TAP_C1 = 18'sd54822;
    localparam logic signed [TAP_W-1:0] TAP_C2 = 18'sd14689;
    localparam logic signed [TAP_W-1:0] TAP_C3 = -18'sd8481;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } opcode_t;

    // sequencer to filter: accumulate enable and tap position
    typedef struct packed {
        logic       en;
        logic [1:0] tap;
    } mac_ctl_t;

    function automatic logic signed [TAP_W-1:0] tap_s(input logic [1:0] w);
        logic signed [TAP_W-1:0] t;
        unique case (w)
            2'd0:    t = TAP_C0;
            2'd1:    t = TAP_C1;
            2'd2:    t = TAP_C2;
            default: t = TAP_C3;
        endcase
        return t;
    endfunction

    function automatic logic signed [TAP_W-1:0] tap_d(input logic [1:0] w);
        logic signed [TAP_W-1:0] t;
        unique case (w)
            2'd0:    t = TAP_C3;
            2'd1:    t = -TAP_C2;
            2'd2:    t = TAP_C1;
            default: t = -TAP_C0;
        endcase
        return t;
    endfunction

    // round half up at bit 16, then clamp to the coefficient range
    function automatic logic signed [COEF_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0]    t;
        logic signed [ACC_W-16:0] sh;
        logic signed [COEF_W-1:0] r;
        t  = {acc[ACC_W-1], acc} + (ACC_W+1)'(32768);
        sh = t[ACC_W:16];
        if (sh > 29'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (sh < -29'sd8388608) begin
            r = -24'sh800000;
        end else begin
            r = sh[COEF_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/d4w_ram.sv
`timescale 1ns / 1ps
// simple dual-port ram, one write and one registered read port
// no dependencies
module d4w_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/d4w_filter.sv
`timescale 1ns / 1ps
// four-tap smooth and detail accumulators for three channels
// depends on d4w_pkg
module d4w_filter
    import d4w_pkg::*;
(
    input  logic              aclk,
    input  mac_ctl_t          mac,
    input  logic [WORD_W-1:0] x_word,
    output logic [WORD_W-1:0] s_word,
    output logic [WORD_W-1:0] d_word
);

    for (genvar g = 0; g < CHAN; g++) begin : g_chan
        logic signed [COEF_W-1:0]       x;
        logic signed [COEF_W+TAP_W-1:0] ps;
        logic signed [COEF_W+TAP_W-1:0] pd;
        logic signed [ACC_W-1:0]        acc_s_reg;
        logic signed [ACC_W-1:0]        acc_d_reg;

        assign x  = signed'(x_word[g*COEF_W +: COEF_W]);
        assign ps = x * tap_s(mac.tap);
        assign pd = x * tap_d(mac.tap);

        // first tap restarts the sum
        always_ff @(posedge aclk) begin
            if (mac.en) begin
                acc_s_reg <= (mac.tap == 2'd0 ? '0 : acc_s_reg) + ACC_W'(ps);
                acc_d_reg <= (mac.tap == 2'd0 ? '0 : acc_d_reg) + ACC_W'(pd);
            end
        end

        assign s_word[g*COEF_W +: COEF_W] = round_sat(acc_s_reg);
        assign d_word[g*COEF_W +: COEF_W] = round_sat(acc_d_reg);
    end

endmodule

// File: src/d4w_seq.sv
`timescale 1ns / 1ps
// pass sequencer: row passes then column passes over the coefficient store
// depends on d4w_pkg, d4w_ram, d4w_filter
module d4w_seq
    import d4w_pkg::*;
#(
    parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
    parameter int IMG_HEIGHT = DEF_IMG_HEIGHT
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       start,
    output logic                                       busy,
    output logic                                       done,
    output logic                                       store_rd_en,
    output logic [$clog2(IMG_WIDTH*IMG_HEIGHT)-1:0]    store_rd_addr,
    input  logic [WORD_W-1:0]                          store_rd_data,
    output logic                                       store_wr_en,
    output logic [$clog2(IMG_WIDTH*IMG_HEIGHT)-1:0]    store_wr_addr,
    output logic [WORD_W-1:0]                          store_wr_data
);

    localparam int LINE_DEPTH = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
    localparam int IW = $clog2(LINE_DEPTH);
    localparam int LW = IW + 1;
    localparam int RW = $clog2(IMG_HEIGHT);
    localparam int CW = $clog2(IMG_WIDTH);
    localparam int AW = RW + CW;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_MAC, S_WS, S_WD, S_CRD, S_CWR
    } state_t;

    state_t        state_reg;
    logic          dir_reg;
    logic [LW-1:0] len_reg;
    logic [IW-1:0] k_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] j_reg;
    logic [1:0]    w_reg;
    logic          done_reg;

    logic [LW-1:0] half;
    logic [LW-1:0] mask;
    logic [IW:0]   tap_pos;
    logic [LW-1:0] tap_wrap;
    logic [LW-1:0] hi_pos;
    logic [IW-1:0] lines_last;
    logic          i_last;
    logic          j_last;
    logic          len_last;

    logic              line_wr_en;
    logic [IW-1:0]     line_wr_addr;
    logic [WORD_W-1:0] line_wr_data;
    logic [WORD_W-1:0] line_rd_data;
    logic [WORD_W-1:0] s_word;
    logic [WORD_W-1:0] d_word;
    mac_ctl_t          mac;

    function automatic logic [AW-1:0] line_addr(input logic d, input logic [IW-1:0] k,
                                                input logic [IW-1:0] p);
        logic [AW-1:0] a;
        if (!d) begin
            a = {k[RW-1:0], p[CW-1:0]};
        end else begin
            a = {p[RW-1:0], k[CW-1:0]};
        end
        return a;
    endfunction

    assign half       = len_reg >> 1;
    assign mask       = len_reg - LW'(1);
    assign tap_pos    = {i_reg, 1'b0} + (IW+1)'(w_reg);
    assign tap_wrap   = tap_pos & mask;
    assign hi_pos     = half + LW'(i_reg);
    assign lines_last = dir_reg ? IW'(IMG_WIDTH - 1) : IW'(IMG_HEIGHT - 1);
    assign i_last     = ({1'b0, i_reg} == half - LW'(1));
    assign j_last     = ({1'b0, j_reg} == mask);
    assign len_last   = (len_reg == LW'(2));

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign store_rd_en   = (state_reg == S_RD);
    assign store_rd_addr = line_addr(dir_reg, k_reg, tap_wrap[IW-1:0]);
    assign store_wr_en   = (state_reg == S_CWR);
    assign store_wr_addr = line_addr(dir_reg, k_reg, j_reg);
    assign store_wr_data = line_rd_data;

    assign mac.en  = (state_reg == S_MAC);
    assign mac.tap = w_reg;

    assign line_wr_en   = (state_reg == S_WS) || (state_reg == S_WD);
    assign line_wr_addr = (state_reg == S_WD) ? hi_pos[IW-1:0] : i_reg;
    assign line_wr_data = (state_reg == S_WD) ? d_word : s_word;

    d4w_filter u_filter (
        .aclk   (aclk),
        .mac    (mac),
        .x_word (store_rd_data),
        .s_word (s_word),
        .d_word (d_word)
    );

    d4w_ram #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (WORD_W)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data),
        .rd_en   (state_reg == S_CRD),
        .rd_addr (j_reg),
        .rd_data (line_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            dir_reg   <= 1'b0;
            len_reg   <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            w_reg     <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        dir_reg   <= 1'b0;
                        len_reg   <= LW'(IMG_WIDTH);
                        k_reg     <= '0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        w_reg     <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    state_reg <= S_MAC;
                end
                S_MAC: begin
                    w_reg <= w_reg + 2'd1;
                    state_reg <= (w_reg == 2'd3) ? S_WS : S_RD;
                end
                S_WS: begin
                    state_reg <= S_WD;
                end
                S_WD: begin
                    if (i_last) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= S_CRD;
                    end else begin
                        i_reg     <= i_reg + IW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_CRD: begin
                    state_reg <= S_CWR;
                end
                S_CWR: begin
                    if (!j_last) begin
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_CRD;
                    end else begin
                        j_reg <= '0;
                        if (k_reg != lines_last) begin
                            k_reg     <= k_reg + IW'(1);
                            state_reg <= S_RD;
                        end else begin
                            k_reg <= '0;
                            if (!len_last) begin
                                len_reg   <= len_reg >> 1;
                                state_reg <= S_RD;
                            end else if (!dir_reg) begin
                                dir_reg   <= 1'b1;
                                len_reg   <= LW'(IMG_HEIGHT);
                                state_reg <= S_RD;
                            end else begin
                                dir_reg   <= 1'b0;
                                len_reg   <= '0;
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/d4_wavelet_2d_decompose_core.sv
`timescale 1ns / 1ps
// top level of the multilevel 2d d4 wavelet decomposition core
// depends on d4w_pkg, d4w_ram, d4w_seq (with d4w_filter)
//
// The core holds a three-channel image of IMG_WIDTH x IMG_HEIGHT coefficients
// in one store ram (24-bit signed per channel, COEF_FRAC_BITS fraction bits).
// Every input item returns exactly one result item. Load (opcode 0) scales
// the three 8-bit samples by norm_scale and writes them; loads outside the
// image are dropped. Read (opcode 2) returns the three coefficients with
// is_read_data set, or zeros outside the image. Run (opcode 1) does every
// row pass (length halving from IMG_WIDTH to 2), then every column pass,
// and acknowledges when the last one is written back. Opcode 3 is just
// acknowledged. One item is handled at a time: a new item is accepted only
// after the last result is taken, and the pace is limited by the registered
// store ram read and the single result register. A load or an unused opcode
// goes from the command stage to the result register; a read goes through the
// command stage and the read stage. A run does, per line pass, four store reads
// per output pair on the one read port, plus two line-buffer writes, then copies
// the line buffer back, over all passes of both directions.
// The store has no reset; entries must be loaded before they are read or run.
// norm_scale (reset 512) may only be written while the core is idle.
module d4_wavelet_2d_decompose_core
    import d4w_pkg::*;
#(
    parameter int IMG_WIDTH      = DEF_IMG_WIDTH,
    parameter int IMG_HEIGHT     = DEF_IMG_HEIGHT,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [SCALE_W-1:0]       cfg_wr_data,
    // input items
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_opcode,
    input  logic [6:0]               s_row_index,
    input  logic [6:0]               s_col_index,
    input  logic [PIX_W-1:0]         s_red_sample,
    input  logic [PIX_W-1:0]         s_green_sample,
    input  logic [PIX_W-1:0]         s_blue_sample,
    // result items
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [COEF_W-1:0] m_red_coef,
    output logic signed [COEF_W-1:0] m_green_coef,
    output logic signed [COEF_W-1:0] m_blue_coef,
    output logic                     m_is_read_data
);

    localparam int RW    = $clog2(IMG_HEIGHT);
    localparam int CW    = $clog2(IMG_WIDTH);
    localparam int AW    = RW + CW;
    localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;

    // configuration register
    logic [SCALE_W-1:0] norm_scale_reg;

    // command stage: valid in the cycle after accept
    logic                  c1_valid_reg;
    opcode_t               c1_op_reg;
    logic                  c1_inside_reg;
    logic [AW-1:0]         c1_addr_reg;
    logic [CHAN*PROD_W-1:0] c1_prod_reg;

    // read stage: store data is valid here
    logic r2_valid_reg;
    logic r2_inside_reg;

    // result register
    logic                     m_valid_reg;
    logic signed [COEF_W-1:0] m_red_reg;
    logic signed [COEF_W-1:0] m_green_reg;
    logic signed [COEF_W-1:0] m_blue_reg;
    logic                     m_read_reg;

    logic run_busy_reg;

    logic              accept;
    logic              in_inside;
    logic [AW-1:0]     in_addr;
    logic [WORD_W-1:0] ld_word;

    // store ports, shared between host commands and the pass sequencer
    logic              st_wr_en;
    logic [AW-1:0]     st_wr_addr;
    logic [WORD_W-1:0] st_wr_data;
    logic              st_rd_en;
    logic [AW-1:0]     st_rd_addr;
    logic [WORD_W-1:0] st_rd_data;

    logic              seq_busy;
    logic              seq_done;
    logic              seq_rd_en;
    logic [AW-1:0]     seq_rd_addr;
    logic              seq_wr_en;
    logic [AW-1:0]     seq_wr_addr;
    logic [WORD_W-1:0] seq_wr_data;

    // one item in flight at a time
    assign s_ready = !c1_valid_reg && !r2_valid_reg && !run_busy_reg && !m_valid_reg;
    assign accept  = s_valid && s_ready;

    assign in_inside = (int'(s_row_index) < IMG_HEIGHT) && (int'(s_col_index) < IMG_WIDTH);
    assign in_addr   = {RW'(s_row_index), CW'(s_col_index)};

    // pixel scaling: Q.16 product brought to the coefficient format, clamped
    for (genvar g = 0; g < CHAN; g++) begin : g_scale
        logic [47:0] pw;
        logic [47:0] v;
        assign pw = {24'd0, c1_prod_reg[g*PROD_W +: PROD_W]};
        if (COEF_FRAC_BITS < 16) begin : g_round
            assign v = (pw + (48'd1 << (16 - COEF_FRAC_BITS - 1))) >> (16 - COEF_FRAC_BITS);
        end else begin : g_shift
            assign v = pw << (COEF_FRAC_BITS - 16);
        end
        assign ld_word[g*COEF_W +: COEF_W] = (v > 48'd8388607) ? 24'h7FFFFF : v[COEF_W-1:0];
    end

    // host access owns the store unless a run is in progress
    always_comb begin
        if (seq_busy) begin
            st_wr_en   = seq_wr_en;
            st_wr_addr = seq_wr_addr;
            st_wr_data = seq_wr_data;
            st_rd_en   = seq_rd_en;
            st_rd_addr = seq_rd_addr;
        end else begin
            st_wr_en   = c1_valid_reg && (c1_op_reg == OP_LOAD) && c1_inside_reg;
            st_wr_addr = c1_addr_reg;
            st_wr_data = ld_word;
            st_rd_en   = c1_valid_reg && (c1_op_reg == OP_READ);
            st_rd_addr = c1_addr_reg;
        end
    end

    d4w_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    d4w_seq #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (c1_valid_reg && (c1_op_reg == OP_RUN)),
        .busy          (seq_busy),
        .done          (seq_done),
        .store_rd_en   (seq_rd_en),
        .store_rd_addr (seq_rd_addr),
        .store_rd_data (st_rd_data),
        .store_wr_en   (seq_wr_en),
        .store_wr_addr (seq_wr_addr),
        .store_wr_data (seq_wr_data)
    );

    // payload of the command stage, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            c1_op_reg     <= opcode_t'(s_opcode);
            c1_inside_reg <= in_inside;
            c1_addr_reg   <= in_addr;
            c1_prod_reg   <= {PROD_W'(s_blue_sample) * PROD_W'(norm_scale_reg),
                              PROD_W'(s_green_sample) * PROD_W'(norm_scale_reg),
                              PROD_W'(s_red_sample) * PROD_W'(norm_scale_reg)};
        end
        if (c1_valid_reg) begin
            r2_inside_reg <= c1_inside_reg;
        end
    end

    // control and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_scale_reg <= NORM_RESET;
            c1_valid_reg   <= 1'b0;
            r2_valid_reg   <= 1'b0;
            run_busy_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_red_reg      <= '0;
            m_green_reg    <= '0;
            m_blue_reg     <= '0;
            m_read_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                norm_scale_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            c1_valid_reg <= accept;
            r2_valid_reg <= 1'b0;

            if (c1_valid_reg) begin
                case (c1_op_reg)
                    OP_READ: r2_valid_reg <= 1'b1;
                    OP_RUN:  run_busy_reg <= 1'b1;
                    default: begin
                        // load and unused opcode: plain acknowledgement
                        m_valid_reg <= 1'b1;
                        m_red_reg   <= '0;
                        m_green_reg <= '0;
                        m_blue_reg  <= '0;
                        m_read_reg  <= 1'b0;
                    end
                endcase
            end

            if (r2_valid_reg) begin
                m_valid_reg <= 1'b1;
                m_read_reg  <= 1'b1;
                if (r2_inside_reg) begin
                    m_red_reg   <= st_rd_data[0*COEF_W +: COEF_W];
                    m_green_reg <= st_rd_data[1*COEF_W +: COEF_W];
                    m_blue_reg  <= st_rd_data[2*COEF_W +: COEF_W];
                end else begin
                    m_red_reg   <= '0;
                    m_green_reg <= '0;
                    m_blue_reg  <= '0;
                end
            end

            // run finished: acknowledge it
            if (seq_done) begin
                run_busy_reg <= 1'b0;
                m_valid_reg  <= 1'b1;
                m_red_reg    <= '0;
                m_green_reg  <= '0;
                m_blue_reg   <= '0;
                m_read_reg   <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_red_coef     = m_red_reg;
    assign m_green_coef   = m_green_reg;
    assign m_blue_coef    = m_blue_reg;
    assign m_is_read_data = m_read_reg;

endmodule

// File: src/d4w_checker.sv
`timescale 1ns / 1ps
// port-level checker for the d4 wavelet core, bound to the top level
// depends on d4w_pkg and assert_macros.svh
`include "assert_macros.svh"

module d4w_checker
    import d4w_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     cfg_wr_en,
    input logic [SCALE_W-1:0]       cfg_wr_data,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [1:0]               s_opcode,
    input logic [6:0]               s_row_index,
    input logic [6:0]               s_col_index,
    input logic [PIX_W-1:0]         s_red_sample,
    input logic [PIX_W-1:0]         s_green_sample,
    input logic [PIX_W-1:0]         s_blue_sample,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [COEF_W-1:0] m_red_coef,
    input logic signed [COEF_W-1:0] m_green_coef,
    input logic signed [COEF_W-1:0] m_blue_coef,
    input logic                     m_is_read_data
);

    // a pending result is held until taken
    `D4W_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // acknowledgements carry zero coefficients
    `D4W_ASSERT(a_ack_zero, aclk, aresetn, (m_valid && !m_is_read_data) |-> (m_red_coef == '0 && m_green_coef == '0 && m_blue_coef == '0))

    // only one item in flight: no accept right after an accept
    `D4W_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a taken result is not followed at once by another
    `D4W_ASSERT_NEXT(a_no_dup, aclk, aresetn, m_valid && m_ready, !m_valid)

    // input is never accepted while a result waits
    `D4W_ASSERT(a_no_accept_full, aclk, aresetn, m_valid |-> !s_ready)

endmodule

bind d4_wavelet_2d_decompose_core d4w_checker u_d4w_checker (.*);

// File: verif/d4_wavelet_2d_decompose_checker.sv
`timescale 1ns / 1ps
// predictor and scoreboard for the d4 wavelet core: follows all three channels and the scale register
// depends on d4w_pkg
module d4_wavelet_2d_decompose_checker
    import d4w_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [SCALE_W-1:0]       cfg_wr_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [1:0]               s_opcode,
    input  logic [6:0]               s_row_index,
    input  logic [6:0]               s_col_index,
    input  logic [PIX_W-1:0]         s_red_sample,
    input  logic [PIX_W-1:0]         s_green_sample,
    input  logic [PIX_W-1:0]         s_blue_sample,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [COEF_W-1:0] m_red_coef,
    input  logic signed [COEF_W-1:0] m_green_coef,
    input  logic signed [COEF_W-1:0] m_blue_coef,
    input  logic                     m_is_read_data,
    output int                       fail_count,
    output int                       pending,
    output int                       reads_seen,
    output int                       runs_seen
);

    localparam int SIDE = 128;
    localparam longint K0 = 31651;
    localparam longint K1 = 54822;
    localparam longint K2 = 14689;
    localparam longint K3 = -8481;

    typedef struct {
        logic signed [COEF_W-1:0] coef [CHAN];
        logic                     rd;
    } coef_item_t;

    int                  image [CHAN][SIDE*SIDE];
    coef_item_t          coef_fifo [$];
    logic [SCALE_W-1:0]  scale_q;

    function automatic int pixel_coef(input logic [PIX_W-1:0] px, input logic [SCALE_W-1:0] sc);
        longint p;
        p = (longint'(px) * longint'(sc) + 2) >> 2;
        if (p > 8388607) p = 8388607;
        return int'(p);
    endfunction

    function automatic int round_clip(input longint acc);
        longint v;
        v = (acc + 32768) >>> 16;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return int'(v);
    endfunction

    // one periodic d4 step on the first len entries of a row or column
    task automatic filter_line(input int c, input int base, input int stride, input int len);
        int     half;
        int     buf_line [SIDE];
        longint x [4];
        half = len / 2;
        for (int i = 0; i < half; i++) begin
            for (int w = 0; w < 4; w++) x[w] = image[c][base + ((2*i + w) % len) * stride];
            buf_line[i] = round_clip(x[0]*K0 + x[1]*K1 + x[2]*K2 + x[3]*K3);
            buf_line[half+i] = round_clip(x[0]*K3 - x[1]*K2 + x[2]*K1 - x[3]*K0);
        end
        for (int i = 0; i < 2*half; i++) image[c][base + i*stride] = buf_line[i];
    endtask

    task automatic decompose_image();
        for (int len = SIDE; len >= 2; len = len / 2)
            for (int k = 0; k < SIDE; k++)
                for (int c = 0; c < CHAN; c++) filter_line(c, k*SIDE, 1, len);
        for (int len = SIDE; len >= 2; len = len / 2)
            for (int k = 0; k < SIDE; k++)
                for (int c = 0; c < CHAN; c++) filter_line(c, k, SIDE, len);
    endtask

    always @(posedge aclk) begin
        coef_item_t e;
        coef_item_t got;
        int         pos;
        logic       bad;
        if (!aresetn) begin
            scale_q <= NORM_RESET;
        end else begin
            if (cfg_wr_en) scale_q <= cfg_wr_data;
            // predict first so a same-edge result still pops the oldest item
            if (s_valid && s_ready) begin
                pos = int'(s_row_index) * SIDE + int'(s_col_index);
                for (int c = 0; c < CHAN; c++) e.coef[c] = '0;
                e.rd = 1'b0;
                case (opcode_t'(s_opcode))
                    OP_LOAD: begin
                        image[0][pos] = pixel_coef(s_red_sample, scale_q);
                        image[1][pos] = pixel_coef(s_green_sample, scale_q);
                        image[2][pos] = pixel_coef(s_blue_sample, scale_q);
                    end
                    OP_RUN: begin
                        decompose_image();
                        runs_seen++;
                    end
                    OP_READ: begin
                        for (int c = 0; c < CHAN; c++) e.coef[c] = image[c][pos][COEF_W-1:0];
                        e.rd = 1'b1;
                    end
                    default: ;
                endcase
                coef_fifo.push_back(e);
            end
            if (m_valid && m_ready) begin
                got.coef[0] = m_red_coef;
                got.coef[1] = m_green_coef;
                got.coef[2] = m_blue_coef;
                got.rd      = m_is_read_data;
                if (coef_fifo.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result item at %0t", $realtime);
                end else begin
                    e = coef_fifo.pop_front();
                    bad = (got.rd !== e.rd);
                    for (int c = 0; c < CHAN; c++) bad |= (got.coef[c] !== e.coef[c]);
                    if (e.rd) reads_seen++;
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch at %0t: expected %0d %0d %0d rd=%0b, got %0d %0d %0d rd=%0b",
                                $realtime, e.coef[0], e.coef[1], e.coef[2], e.rd,
                                got.coef[0], got.coef[1], got.coef[2], got.rd);
                    end
                end
            end
            pending <= coef_fifo.size();
        end
    end

    initial begin
        fail_count = 0;
        pending    = 0;
        reads_seen = 0;
        runs_seen  = 0;
    end

    final begin
        if (coef_fifo.size() != 0) $display("%0d result items never arrived", coef_fifo.size());
    end

endmodule

// File: verif/d4_wavelet_2d_decompose_core_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the d4 wavelet core; checking lives in the checker module
// depends on d4w_pkg, d4_wavelet_2d_decompose_core, d4_wavelet_2d_decompose_checker
module d4_wavelet_2d_decompose_core_tb;
    import d4w_pkg::*;

    localparam int SIDE       = 128;
    localparam int IDLE_LIMIT = 2000000;
    localparam int HOLD_LEN   = 400;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [SCALE_W-1:0] cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_opcode = OP_NOP;
    logic [6:0]         s_row_index = '0;
    logic [6:0]         s_col_index = '0;
    logic [PIX_W-1:0]   s_red_sample = '0;
    logic [PIX_W-1:0]   s_green_sample = '0;
    logic [PIX_W-1:0]   s_blue_sample = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [COEF_W-1:0] m_red_coef, m_green_coef, m_blue_coef;
    logic               m_is_read_data;

    int fail_count, pending, reads_seen, runs_seen;

    // sender pacing and receiver hold-off
    int   burst_left = 0;
    bit   gaps_on = 1'b1;
    logic hold_req = 1'b0;
    bit   hold_taken = 1'b0;
    int   hold_left = 0;
    logic [15:0] rx_cyc = '0;
    int   idle_cycles = 0;

    // positions already loaded, so reads never touch an unwritten entry
    bit          loaded [SIDE*SIDE];
    logic [13:0] loaded_pos [$];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    d4_wavelet_2d_decompose_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_row_index(s_row_index), .s_col_index(s_col_index),
        .s_red_sample(s_red_sample), .s_green_sample(s_green_sample),
        .s_blue_sample(s_blue_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_red_coef(m_red_coef),
        .m_green_coef(m_green_coef), .m_blue_coef(m_blue_coef),
        .m_is_read_data(m_is_read_data)
    );

    d4_wavelet_2d_decompose_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_row_index(s_row_index), .s_col_index(s_col_index),
        .s_red_sample(s_red_sample), .s_green_sample(s_green_sample),
        .s_blue_sample(s_blue_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_red_coef(m_red_coef),
        .m_green_coef(m_green_coef), .m_blue_coef(m_blue_coef),
        .m_is_read_data(m_is_read_data),
        .fail_count(fail_count), .pending(pending),
        .reads_seen(reads_seen), .runs_seen(runs_seen)
    );

    // receiver: rotates through its own stall patterns, plus one long hold-off
    always @(posedge aclk) begin
        rx_cyc <= rx_cyc + 16'd1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_LEN;
            m_ready    <= 1'b0;
        end else begin
            case (rx_cyc[10:9])
                2'd0:    m_ready <= 1'b1;
                2'd1:    m_ready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_ready <= (rx_cyc[2:0] != 3'd5);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog: ends the run after too long without any item moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // offer one item, with burst gaps in front; returns at the accepting edge
    task automatic send_item(input opcode_t op, input int row, input int col,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_row_index    <= row[6:0];
        s_col_index    <= col[6:0];
        s_red_sample   <= r;
        s_green_sample <= g;
        s_blue_sample  <= b;
        if (op == OP_LOAD && !loaded[row*SIDE+col]) begin
            loaded[row*SIDE+col] = 1'b1;
            loaded_pos.push_back(14'(row*SIDE+col));
        end
        // ready only moves at rising edges, so the falling edge sees it settled
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    task automatic read_at(input int pos);
        send_item(OP_READ, pos / SIDE, pos % SIDE, 8'($urandom()), 8'($urandom()),
                  8'($urandom()));
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom());
        endcase
    endfunction

    // drain everything, then write the scale register while the core is idle
    task automatic set_scale(input logic [15:0] v);
        s_valid <= 1'b0;
        // one edge first so the count includes an item accepted just now
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: corners at full scale, all-zero and all-one samples, unused opcode
        set_scale(16'hFFFF);
        send_item(OP_LOAD, 0, 0, 8'd255, 8'd255, 8'd255);
        send_item(OP_LOAD, 127, 127, 8'd0, 8'd0, 8'd0);
        send_item(OP_LOAD, 0, 127, 8'd255, 8'd0, 8'd128);
        send_item(OP_LOAD, 127, 0, 8'd1, 8'd2, 8'd3);
        send_item(OP_NOP, 127, 127, 8'd255, 8'd255, 8'd255);
        read_at(0);
        read_at(127*SIDE + 127);
        read_at(127);
        read_at(127*SIDE);
        // zero scale loads zeros, smallest nonzero scale rounds tiny products
        set_scale(16'd0);
        send_item(OP_LOAD, 5, 5, 8'd200, 8'd255, 8'd1);
        read_at(5*SIDE + 5);
        set_scale(16'd1);
        send_item(OP_LOAD, 6, 6, 8'd255, 8'd2, 8'd1);
        read_at(6*SIDE + 6);
        read_at(0);

        // random mix of loads, reads of loaded entries and unused opcodes
        set_scale(NORM_RESET);
        for (int n = 0; n < 1300; n++) begin
            if (n == 300) hold_req <= 1'b1;
            if (n == 650) set_scale(16'($urandom_range(1, 65535)));
            gaps_on = (n < 900 || n > 1100);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_item(OP_LOAD, $urandom_range(0, 127), $urandom_range(0, 127),
                          pick_sample(), pick_sample(), pick_sample());
            else if (pick < 90)
                read_at(loaded_pos[$urandom_range(0, loaded_pos.size() - 1)]);
            else
                send_item(OP_NOP, $urandom_range(0, 127), $urandom_range(0, 127),
                          8'($urandom()), 8'($urandom()), 8'($urandom()));
        end

        // fill the whole image so the transform only sees loaded entries
        set_scale(NORM_RESET);
        for (int p = 0; p < SIDE*SIDE; p++)
            send_item(OP_LOAD, p / SIDE, p % SIDE, pick_sample(), pick_sample(), pick_sample());
        send_item(OP_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                  8'($urandom()), 8'($urandom()), 8'($urandom()));
        // low-pass corner, the last detail entries and random spots after the run
        read_at(0);
        read_at(1);
        read_at(SIDE);
        read_at(SIDE*SIDE - 1);
        for (int n = 0; n < 200; n++) read_at($urandom_range(0, SIDE*SIDE - 1));

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("covered %0d loads into a full image, %0d transform runs, %0d reads checked",
                 SIDE*SIDE, runs_seen, reads_seen);
        $display("scale settings went through zero, one, the reset value and all ones");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
